@@ hdl/ausp_pkg.sv @@
package ausp_pkg;

  localparam int unsigned LENGTH_BITS   = 24;
  localparam int unsigned OUT_BITS      = 24;
  localparam int unsigned CFG_BITS      = 24;
  localparam int unsigned CMP_BITS      = 33;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic [LENGTH_BITS-1:0] POS_MAX       = {LENGTH_BITS{1'b1}};
  localparam logic [OUT_BITS-1:0]    OUT_MAX       = {OUT_BITS{1'b1}};
  localparam logic [CFG_BITS-1:0]    MAX_BYTES_RST = {CFG_BITS{1'b1}};

  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] BYTE_ONE       = 8'h01;
  localparam logic [4:0] NAL_SLICE      = 5'd1;
  localparam logic [4:0] NAL_SLICE_IDR  = 5'd5;
  localparam int unsigned FIRST_MB_BIT  = 7;

  typedef struct packed {
    logic [OUT_BITS-1:0] unit_length;
    logic                too_long;
    logic                final_frame;
    logic                run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t result_make(input logic [LENGTH_BITS-1:0] len,
                                          input logic [CFG_BITS-1:0]    max_bytes,
                                          input logic                   fin,
                                          input logic                   last);
    result_t             r;
    logic [CMP_BITS-1:0] len_x;
    logic [CMP_BITS-1:0] max_x;
    logic [CMP_BITS-1:0] out_max_x;
    len_x       = CMP_BITS'(len);
    max_x       = CMP_BITS'(max_bytes);
    out_max_x   = CMP_BITS'(OUT_MAX);
    r.too_long  = (len_x > max_x) || (len == POS_MAX) || (len_x > out_max_x);
    r.unit_length  = (len_x > out_max_x) ? OUT_MAX : len_x[OUT_BITS-1:0];
    r.final_frame  = fin;
    r.run_last     = last;
    return r;
  endfunction

endpackage

@@ hdl/ausp_in_if.sv @@
interface ausp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

@@ hdl/ausp_out_if.sv @@
interface ausp_out_if;
  import ausp_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] unit_length;
  logic                too_long;
  logic                final_frame;
  logic                run_last;

  modport source (output valid, output unit_length, output too_long,
                  output final_frame, output run_last, input ready);
  modport sink   (input valid, input unit_length, input too_long,
                  input final_frame, input run_last, output ready);
endinterface

@@ hdl/ausp_scanner.sv @@
module ausp_scanner
  import ausp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  ausp_in_if.sink             in_i,
  input  logic                room_i,
  output push_t               push_o
);

  typedef enum logic [2:0] {
    SC_NONE,
    SC_ZERO1,
    SC_ZERO2,
    SC_ZERO3,
    SC_NALHDR,
    SC_SLICE
  } scan_e;

  logic                   in_valid_q;
  logic [7:0]             byte_q;
  logic                   end_q;
  logic [CFG_BITS-1:0]    max_bytes_q;
  scan_e                  scan_q, scan_d;
  logic                   slice_q, slice_d;
  logic [LENGTH_BITS-1:0] code_pos_q, code_pos_d;
  logic [LENGTH_BITS-1:0] frame_pos_q, frame_pos_d;

  logic                   fire;
  logic                   cut;
  logic                   cut_slice;
  logic [LENGTH_BITS-1:0] pos_inc;
  logic [LENGTH_BITS-1:0] cut_len;
  logic [LENGTH_BITS-1:0] rest_len;
  logic                   is_slice;

  assign fire       = in_valid_q && room_i;
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
      end_q  <= in_i.stream_end;
    end
  end

  assign is_slice = (byte_q[4:0] == NAL_SLICE) || (byte_q[4:0] == NAL_SLICE_IDR);
  assign pos_inc  = (frame_pos_q == POS_MAX) ? POS_MAX : frame_pos_q + 1'b1;
  assign cut_len  = (code_pos_q <= pos_inc) ? code_pos_q : pos_inc;

  always_comb begin
    scan_d     = scan_q;
    slice_d    = slice_q;
    code_pos_d = code_pos_q;
    cut        = 1'b0;
    cut_slice  = 1'b0;
    case (scan_q)
      SC_NONE: begin
        if (byte_q == BYTE_ZERO) begin
          scan_d     = SC_ZERO1;
          code_pos_d = frame_pos_q;
        end
      end
      SC_ZERO1: scan_d = (byte_q == BYTE_ZERO) ? SC_ZERO2 : SC_NONE;
      SC_ZERO2: begin
        if (byte_q == BYTE_ONE) begin
          scan_d = SC_NALHDR;
        end else if (byte_q == BYTE_ZERO) begin
          scan_d = SC_ZERO3;
        end else begin
          scan_d = SC_NONE;
        end
      end
      SC_ZERO3: scan_d = (byte_q == BYTE_ONE) ? SC_NALHDR : SC_NONE;
      SC_NALHDR: begin
        if (is_slice) begin
          scan_d = SC_SLICE;
        end else begin
          scan_d = SC_NONE;
          cut    = slice_q;
        end
      end
      SC_SLICE: begin
        scan_d = SC_NONE;
        if (byte_q[FIRST_MB_BIT]) begin
          if (slice_q) begin
            cut       = 1'b1;
            cut_slice = 1'b1;
          end else begin
            slice_d = 1'b1;
          end
        end
      end
      default: scan_d = SC_NONE;
    endcase

    rest_len    = pos_inc;
    frame_pos_d = pos_inc;
    if (cut) begin
      rest_len    = pos_inc - cut_len;
      frame_pos_d = rest_len;
      code_pos_d  = '0;
      slice_d     = cut_slice;
      scan_d      = SC_NONE;
    end
    if (end_q) begin
      frame_pos_d = '0;
      code_pos_d  = '0;
      slice_d     = 1'b0;
      scan_d      = SC_NONE;
    end
  end

  always_comb begin
    push_o.count  = 2'd0;
    push_o.first  = result_make(rest_len, max_bytes_q, 1'b1, 1'b1);
    push_o.second = result_make(rest_len, max_bytes_q, 1'b1, 1'b1);
    if (fire) begin
      if (cut) begin
        push_o.first = result_make(cut_len, max_bytes_q, 1'b0, !end_q);
        push_o.count = end_q ? 2'd2 : 2'd1;
      end else if (end_q) begin
        push_o.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MAX_BYTES_RST;
      scan_q      <= SC_NONE;
      slice_q     <= 1'b0;
      code_pos_q  <= '0;
      frame_pos_q <= '0;
    end else begin
      if (cfg_we_i) begin
        max_bytes_q <= cfg_data_i;
      end
      if (fire) begin
        scan_q      <= scan_d;
        slice_q     <= slice_d;
        code_pos_q  <= code_pos_d;
        frame_pos_q <= frame_pos_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && end_q |=> frame_pos_q == '0 && scan_q == SC_NONE && !slice_q)
    else $error("stream state not cleared after end of stream");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |-> fire && end_q && cut)
    else $error("double push without a cut on the end byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_pos_q <= frame_pos_q)
    else $error("start code position beyond frame position");

endmodule

@@ hdl/ausp_result_fifo.sv @@
module ausp_result_fifo
  import ausp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      room_o,
  ausp_out_if.source out_o
);

  result_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_BITS-1:0] count_q, count_d;
  logic [FIFO_PTR_BITS-1:0] wr_ptr_next;
  logic                     pop;
  result_t                  head;

  assign pop         = out_o.valid && out_o.ready;
  assign room_o      = count_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
  assign wr_ptr_next = wr_ptr_q + 1'b1;
  assign head        = mem_q[rd_ptr_q];

  assign out_o.valid        = count_q != '0;
  assign out_o.unit_length  = head.unit_length;
  assign out_o.too_long     = head.too_long;
  assign out_o.final_frame  = head.final_frame;
  assign out_o.run_last     = head.run_last;

  assign wr_ptr_d = wr_ptr_q + FIFO_PTR_BITS'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + FIFO_PTR_BITS'(pop);
  assign count_d  = count_q + FIFO_CNT_BITS'(push_i.count) - FIFO_CNT_BITS'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o)
    else $error("push into a queue without room");

endmodule

@@ hdl/h264_access_unit_splitter.sv @@
// channel  direction  payload                                        transaction when
// in_i     sink       data_byte[7:0], stream_end                     valid && ready
// out_o    source     unit_length[23:0], too_long, final_frame,      valid && ready
//                     run_last
// cfg      write      cfg_data_i[23:0] (max_frame_bytes)             cfg_we_i
//
// One byte per cycle sustained while the result queue has room; a byte is held in the
// input register until the scanner takes it. Its results are then written into a
// four-entry queue whose head drives the output directly.
// A cut on the final byte gives two results; both enter the queue in the same cycle.
// Input stalls only while the result queue holds more than two results.
// Reset clears scanner state, queue and sets max_frame_bytes to all ones.
module h264_access_unit_splitter
  import ausp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  ausp_in_if.sink             in_i,
  ausp_out_if.source          out_o
);

  push_t push;
  logic  room;

  ausp_scanner u_scanner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .room_i     (room),
    .push_o     (push)
  );

  ausp_result_fifo u_result_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
